/* rtl/core/i2d_pkg.sv */
`timescale 1ns / 1ps

package i2d_pkg;

  // Width of the value port and the number of its low bits that are converted.
  localparam int VALUE_W    = 64;
  localparam int VALUE_BITS = 64;

  // Decimal digits needed for the largest VALUE_BITS-bit magnitude.
  // 1233 / 4096 is a close lower approximation of log10(2).
  localparam int NDIG = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCDW = 4 * NDIG;
  localparam int IDXW = $clog2(NDIG);

  // Binary bits consumed by each conversion stage, and the stage count.
  localparam int BPS  = 8;
  localparam int NSTG = (VALUE_BITS + BPS - 1) / BPS;
  localparam int PADW = NSTG * BPS;

  // ASCII codes.
  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // Selector codes.
  localparam logic FUNC_SIGNED   = 1'b0;
  localparam logic FUNC_UNSIGNED = 1'b1;

  // Item as it travels through the conversion stages.
  typedef struct packed {
    logic            neg;
    logic [PADW-1:0] bin;
    logic [BCDW-1:0] bcd;
  } dd_t;

  // One shift-and-add-3 step: correct every digit, then shift in one bit.
  function automatic logic [BCDW-1:0] dabble(input logic [BCDW-1:0] bcd_in,
                                             input logic            bit_in);
    logic [BCDW-1:0] d;
    d = bcd_in;
    for (int i = 0; i < NDIG; i++) begin
      if (d[4*i +: 4] >= 4'd5) begin
        d[4*i +: 4] = d[4*i +: 4] + 4'd3;
      end
    end
    return {d[BCDW-2:0], bit_in};
  endfunction

endpackage

/* rtl/core/i2d_sign.sv */
`timescale 1ns / 1ps

module i2d_sign import i2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               func_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dd_t                data_o
);

  logic                  valid_q;
  dd_t                   data_q, data_d;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;

  // Take the magnitude as an unsigned quantity so the most negative value
  // converts exactly.
  always_comb begin
    raw = value_i[VALUE_BITS-1:0];
    neg = (func_i == FUNC_SIGNED) && raw[VALUE_BITS-1];
    mag = neg ? (~raw + 1'b1) : raw;
    data_d.neg = neg;
    data_d.bin = PADW'(mag) << (PADW - VALUE_BITS);
    data_d.bcd = '0;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register: advances whenever the next stage can take the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/i2d_dabble.sv */
`timescale 1ns / 1ps

module i2d_dabble import i2d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dd_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output dd_t  data_o
);

  logic valid_q;
  dd_t  data_q, data_d;

  // Shift BPS binary bits, most significant first, into the BCD digits.
  always_comb begin
    data_d = data_i;
    for (int i = 0; i < BPS; i++) begin
      data_d.bcd = dabble(data_d.bcd, data_d.bin[PADW-1]);
      data_d.bin = data_d.bin << 1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register with its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/i2d_serial.sv */
`timescale 1ns / 1ps

module i2d_serial import i2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dd_t               data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [CHAR_W-1:0] text_char_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SIGN  = 3'b010,
    S_DIGIT = 3'b100
  } ser_state_e;

  ser_state_e      state_q, state_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [3:0]      dig_q [NDIG];
  logic [IDXW-1:0] msd;
  logic            load;
  logic            beat;

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (data_i.bcd[4*i +: 4] != 4'd0) begin
        msd = IDXW'(i);
      end
    end
  end

  assign ready_o = (state_q == S_IDLE);
  assign load    = valid_i && ready_o;
  assign beat    = valid_o && ready_i;

  // Sequencer: optional sign, then digits from the top one down.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          state_d = data_i.neg ? S_SIGN : S_DIGIT;
          idx_d   = msd;
        end
      end
      S_SIGN: begin
        if (beat) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (beat) begin
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Digit holding register, loaded when a new number arrives.
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NDIG; i++) begin
        dig_q[i] <= data_i.bcd[4*i +: 4];
      end
    end
  end

  // Output character.
  assign valid_o     = (state_q == S_SIGN) || (state_q == S_DIGIT);
  assign text_char_o = (state_q == S_SIGN) ? CHAR_MINUS
                                           : (CHAR_ZERO + {3'b000, dig_q[idx_q]});
  assign last_o      = (state_q == S_DIGIT) && (idx_q == '0);

endmodule

/* rtl/core/int64_to_decimal_text.sv */
`timescale 1ns / 1ps

// Binary to decimal ASCII converter.
// Input channel (in_valid_i / in_ready_o): one beat carries a 64-bit value_i
// and func_i (0 = signed two's complement, 1 = unsigned).
// Output channel (out_valid_o / out_ready_i): one beat per character, most
// significant first, as 7-bit ASCII in text_char_o. Negative signed values
// start with '-'. Zero gives the single character '0'. last_o marks the final
// character of each number. The most negative signed value prints exactly.
// Path to the first character: the sign stage loads at the clock edge of
// the input beat, then eight shift-and-add-3 stages of 8 bits each and one
// serializer load follow before the character is offered.
// The character serializer sends one character per cycle while the receiver
// is ready and returns to idle to load the next number, so it takes no new
// number until the last character of the current one is sent; the conversion
// stages accept a new value every cycle while they have room.
// Reset clears all valid bits and returns the serializer to idle.
// When the receiver stalls, the current character holds and the conversion
// stages fill up, then in_ready_o drops; nothing is lost or repeated.
module int64_to_decimal_text import i2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  text_char_o,
  output logic               last_o
);

  logic stg_valid [NSTG+1];
  logic stg_ready [NSTG+1];
  dd_t  stg_data  [NSTG+1];

  // Sign and magnitude stage.
  i2d_sign u_sign (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .func_i  (func_i),
    .value_i (value_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  // Binary to BCD conversion stages.
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    i2d_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[s]),
      .ready_o (stg_ready[s]),
      .data_i  (stg_data[s]),
      .valid_o (stg_valid[s+1]),
      .ready_i (stg_ready[s+1]),
      .data_o  (stg_data[s+1])
    );
  end

  // Character serializer.
  i2d_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid[NSTG]),
    .ready_o     (stg_ready[NSTG]),
    .data_i      (stg_data[NSTG]),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

  // A number's text continues without a gap until its last character.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("text of a number stopped before its last character");

  // The sign is never the last character and is followed by a digit.
  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (text_char_o == CHAR_MINUS)
    |=> out_valid_o && (text_char_o != CHAR_MINUS) && (text_char_o != CHAR_ZERO))
    else $error("sign not followed by a leading nonzero digit");

  // Every character is a sign or a decimal digit.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (text_char_o == CHAR_MINUS) ||
                    ((text_char_o >= CHAR_ZERO) && (text_char_o <= CHAR_ZERO + 7'd9)))
    else $error("character outside the decimal alphabet");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import i2d_pkg::*;

  // One number waiting to be offered, and one predicted character beat.
  typedef struct {
    logic               func;
    logic [VALUE_W-1:0] value;
    bit                 drain;
  } num_item_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  localparam logic [VALUE_BITS-1:0] RADIX       = 10;
  localparam int                    MAX_CHARS   = 20;
  localparam int                    HOLD_CYCLES = 400;
  localparam int                    HOLD_AFTER  = 150;
  localparam int                    N_RANDOM    = 330;
  localparam int                    LIMIT_NS    = 2000000;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               func        = FUNC_UNSIGNED;
  logic [VALUE_W-1:0] value       = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [CHAR_W-1:0]  text_char;
  logic               last;

  num_item_t  pending_nums[$];
  text_beat_t expected_text[$];

  int  errors        = 0;
  int  chars_seen    = 0;
  int  nums_taken    = 0;
  int  n_drains      = 0;
  int  n_unsigned    = 0;
  int  n_negative    = 0;
  int  n_full_stalls = 0;
  int  send_gap      = 0;
  int  stall_left    = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  rx_holding    = 1'b0;

  int64_to_decimal_text dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .text_char_o (text_char),
    .last_o      (last)
  );

  // Queue one number for the driver.
  function automatic void add_num(input logic f, input logic [VALUE_W-1:0] v,
                                  input bit d);
    num_item_t it;
    it.func  = f;
    it.value = v;
    it.drain = d;
    pending_nums.push_back(it);
  endfunction

  // Predict the characters of one accepted number.
  function automatic void predict(input logic f, input logic [VALUE_W-1:0] v);
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digs [MAX_CHARS];
    int                    nd;
    bit                    neg;
    text_beat_t            b;
    raw = v[VALUE_BITS-1:0];
    neg = (f == FUNC_SIGNED) && raw[VALUE_BITS-1];
    mag = neg ? (VALUE_BITS'(0) - raw) : raw;
    if (f == FUNC_UNSIGNED) n_unsigned++;
    if (neg) n_negative++;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % RADIX);
      nd++;
      mag = mag / RADIX;
    end while (mag != 0 && nd < MAX_CHARS);
    if (neg) begin
      b.ch   = CHAR_MINUS;
      b.last = 1'b0;
      expected_text.push_back(b);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      b.ch   = CHAR_ZERO + {3'b000, digs[k]};
      b.last = (k == 0);
      expected_text.push_back(b);
    end
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: offers queued numbers with random gaps and holds each beat until
  // it is taken. A drain item waits until every expected character is back.
  always @(posedge clk_i) begin : driver
    num_item_t nxt;
    bit        busy;
    if (rst_ni) begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict(func, value);
        nums_taken++;
        busy = 1'b0;
      end
      if (in_valid && !in_ready && rx_holding) n_full_stalls++;
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_nums.size() > 0 &&
                     (!pending_nums[0].drain || expected_text.size() == 0)) begin
          nxt = pending_nums.pop_front();
          func     <= nxt.func;
          value    <= nxt.value;
          in_valid <= 1'b1;
          if (nxt.drain) n_drains++;
          send_gap = ($urandom_range(0, 15) == 0) ? int'($urandom_range(8, 40))
                                                   : int'($urandom_range(0, 2));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold once enough numbers have gone in.
  always @(posedge clk_i) begin : hold_ctrl
    if (rst_ni) begin
      if (rx_holding) begin
        if (hold_left <= 1) begin
          rx_holding <= 1'b0;
          hold_done  <= 1'b1;
        end
        hold_left <= hold_left - 1;
      end else if (!hold_done && nums_taken >= HOLD_AFTER) begin
        rx_holding <= 1'b1;
        hold_left  <= HOLD_CYCLES;
      end
    end
  end

  // Monitor: checks each character beat and drives a randomly gapped ready.
  always @(posedge clk_i) begin : receiver
    text_beat_t exp_beat;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          errors++;
          $display("%0t: expected no character, actual char %h last %b",
                   $time, text_char, last);
        end else begin
          exp_beat = expected_text.pop_front();
          if (text_char !== exp_beat.ch || last !== exp_beat.last) begin
            errors++;
            $display("%0t: mismatch, expected char %h last %b, actual char %h last %b",
                     $time, exp_beat.ch, exp_beat.last, text_char, last);
          end
        end
      end
      if (rx_holding) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 40))
                                                     : int'($urandom_range(1, 3));
        end
      end
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin : main
    logic [VALUE_W-1:0] corners [14];
    logic [VALUE_W-1:0] v;
    int                 n_items;
    corners = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999999999,
                64'd1000000000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                64'd9999999999999999999, 64'd10000000000000000000,
                64'hFFFF_FFFF_FFFF_FFF6, 64'hFFFF_FFFF_FFFF_FFFF};
    foreach (corners[i]) begin
      add_num(FUNC_SIGNED, corners[i], 1'b0);
      add_num(FUNC_UNSIGNED, corners[i], 1'b0);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: v = {$urandom, $urandom};
        1: v = {$urandom, $urandom} >> $urandom_range(1, 63);
        2: v = ~({$urandom, $urandom} >> $urandom_range(1, 63));
        default: v = VALUE_W'($urandom_range(0, 1000));
      endcase
      add_num(1'($urandom_range(0, 1)), v, (i == 120) || (i == 260));
    end
    n_items = pending_nums.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_nums.size() == 0 && !in_valid && expected_text.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (30) @(posedge clk_i);

    if (nums_taken != n_items || expected_text.size() != 0) begin
      errors++;
      $display("%0t: expected %0d numbers taken and no pending text, actual %0d and %0d",
               $time, n_items, nums_taken, expected_text.size());
    end

    $display("Converted %0d numbers (%0d unsigned, %0d negative) into %0d characters.",
             nums_taken, n_unsigned, n_negative, chars_seen);
    $display("Ran corner values, random widths, a %0d-cycle output hold (%0d input %s",
             HOLD_CYCLES, n_full_stalls, $sformatf("stall cycles) and %0d drains.", n_drains));
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit, far above what a complete run needs.
  initial begin
    #(LIMIT_NS);
    $display("%0t: run did not complete in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
